### hdl/dots_pkg.sv
// Package for the deadline ordered timer set: operation and status codes,
// table sizes and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none
package dots_pkg;
    localparam int MAX_TIMERS = 16;
    localparam int ID_W       = 4;
    localparam int TIME_W     = 64;
    localparam logic [TIME_W-1:0] HOUR_MS  = 64'd3600000;
    localparam logic [TIME_W-1:0] ALL_ONES = {TIME_W{1'b1}};

    localparam logic [2:0] FUNC_ADD     = 3'd0;
    localparam logic [2:0] FUNC_CANCEL  = 3'd1;
    localparam logic [2:0] FUNC_REFRESH = 3'd2;
    localparam logic [2:0] FUNC_RESET   = 3'd3;
    localparam logic [2:0] FUNC_EXPIRE  = 3'd4;
    localparam logic [2:0] FUNC_NEXT    = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INACTIVE = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NONE     = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic scan_start;   // clear the running minimum
        logic scan_step;    // compare slot scan_idx against the minimum
        logic [ID_W-1:0] scan_idx;
        logic use_exp;      // scan only slots marked expired
        logic mark_exp;     // build the expired mask (roll in roll_reg)
        logic exp_clear;    // drop min slot from expired mask
        logic do_op;        // apply the table update of the latched op
        logic rearm;        // re-arm or free the minimum slot
        logic upd_prev;     // prev_reg <= now, roll_reg <= roll
        logic clr_front;
        logic front_check;  // after insert: compare minimum with target slot
    } dots_cmd_t;

    typedef struct packed {
        logic            min_found;
        logic [ID_W-1:0] min_idx;
        logic            min_passed; // deadline of min <= now
        logic            min_is_tgt; // minimum found and it is the target slot
        logic            roll;
        logic            free_found;
        logic [ID_W-1:0] free_idx;
        logic            tgt_active;
        logic            reset_same;
        logic            front_pending;
        logic            any_exp;
    } dots_stat_t;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? ALL_ONES : s[TIME_W-1:0];
    endfunction
endpackage
`default_nettype wire

### hdl/deadline_ordered_timer_set_unit.sv
// Top level of the deadline ordered timer set.
// Each item is decided first: rejected or unchanged cancel/refresh/reset go straight
// to the result, cancel/refresh apply the update, add and reset update and then scan
// all slots, next scans once, expire scans then rescans once per expired timer. One
// item at a time, the next after the last result; the serial 16-slot scan paces it.
// Reset (rst_n, asynchronous) frees all slots and clears front and time state.
`default_nettype none
module deadline_ordered_timer_set_unit
    import dots_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [2:0]        func,
    input  wire logic [ID_W-1:0]   timer_id,
    input  wire logic [TIME_W-1:0] interval_ms,
    input  wire logic              recurring,
    input  wire logic              restart_now,
    input  wire logic [TIME_W-1:0] now_ms,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [1:0]             status,
    output logic [ID_W-1:0]        result_id,
    output logic [TIME_W-1:0]      delay_ms,
    output logic                   front_notify,
    output logic                   last
);
    dots_cmd_t cmd;
    dots_stat_t stat;
    logic load, want_delay;
    logic [TIME_W-1:0] delay;

    dots_ctrl u_ctrl (
        .clk, .rst_n, .in_valid, .in_ready, .func, .load, .out_valid, .out_ready,
        .status, .result_id, .want_delay, .front_notify, .last, .cmd, .stat
    );

    dots_datapath u_dp (
        .clk, .rst_n, .load, .func, .timer_id, .interval_ms, .recurring,
        .restart_now, .now_ms, .cmd, .stat, .delay
    );

    assign delay_ms = want_delay ? delay : '0;
endmodule
`default_nettype wire

### hdl/dots_datapath.sv
// Datapath of the timer set: slot table, expired mask, serial minimum scan.
// Depends on dots_pkg.
`default_nettype none
module dots_datapath
    import dots_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire logic [2:0]        func,
    input  wire logic [ID_W-1:0]   timer_id,
    input  wire logic [TIME_W-1:0] interval_ms,
    input  wire logic              recurring,
    input  wire logic              restart_now,
    input  wire logic [TIME_W-1:0] now_ms,
    input  wire dots_cmd_t         cmd,
    output dots_stat_t             stat,
    output logic [TIME_W-1:0]      delay
);
    logic [MAX_TIMERS-1:0] active_reg, exp_reg;
    logic [TIME_W-1:0] deadline_reg [MAX_TIMERS];
    logic [TIME_W-1:0] period_reg [MAX_TIMERS];
    logic [MAX_TIMERS-1:0] repeats_reg;
    logic front_reg, found_reg, roll_reg;
    logic [TIME_W-1:0] prev_reg, min_dl_reg;
    logic [ID_W-1:0] min_idx_reg, tgt_reg;
    logic [2:0] func_reg;
    logic [TIME_W-1:0] ival_reg, now_reg;
    logic rec_reg, fnow_reg;
    logic [ID_W-1:0] op_slot;
    logic free_found;
    logic [ID_W-1:0] free_idx;
    logic [TIME_W-1:0] start, tgt_dl, tgt_per;
    logic sel, better;

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = MAX_TIMERS - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = ID_W'(i);
            end
        end
    end

    assign tgt_dl  = deadline_reg[tgt_reg];
    assign tgt_per = period_reg[tgt_reg];
    assign start   = fnow_reg ? now_reg : (tgt_dl >= tgt_per ? tgt_dl - tgt_per : '0);
    assign op_slot = (func_reg == FUNC_ADD) ? free_idx : tgt_reg;
    assign sel     = cmd.use_exp ? exp_reg[cmd.scan_idx] : active_reg[cmd.scan_idx];
    assign better  = sel && (!found_reg || deadline_reg[cmd.scan_idx] < min_dl_reg);

    assign stat.min_found     = found_reg;
    assign stat.min_idx       = min_idx_reg;
    assign stat.min_passed    = min_dl_reg <= now_reg;
    assign stat.min_is_tgt    = found_reg && min_idx_reg == tgt_reg;
    assign stat.roll          = prev_reg >= HOUR_MS && now_reg < prev_reg - HOUR_MS;
    assign stat.free_found    = free_found;
    assign stat.free_idx      = free_idx;
    assign stat.tgt_active    = active_reg[tgt_reg];
    assign stat.reset_same    = ival_reg == tgt_per && !fnow_reg;
    assign stat.front_pending = front_reg;
    assign stat.any_exp       = |exp_reg;
    assign delay = !found_reg ? ALL_ONES :
                   (now_reg >= min_dl_reg ? '0 : min_dl_reg - now_reg);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            func_reg <= func;
            tgt_reg  <= timer_id;
            ival_reg <= interval_ms;
            rec_reg  <= recurring;
            fnow_reg <= restart_now;
            now_reg  <= now_ms;
        end
        if (cmd.scan_start)
        begin
            min_dl_reg  <= '0;
            min_idx_reg <= '0;
        end
        else if (cmd.scan_step && better)
        begin
            min_dl_reg  <= deadline_reg[cmd.scan_idx];
            min_idx_reg <= cmd.scan_idx;
        end
        if (cmd.do_op)
        begin
            if (func_reg == FUNC_ADD)
            begin
                period_reg[op_slot]   <= ival_reg;
                repeats_reg[op_slot]  <= rec_reg;
                deadline_reg[op_slot] <= sat_add(now_reg, ival_reg);
            end
            else if (func_reg == FUNC_REFRESH)
                deadline_reg[op_slot] <= sat_add(now_reg, tgt_per);
            else if (func_reg == FUNC_RESET)
            begin
                period_reg[op_slot]   <= ival_reg;
                deadline_reg[op_slot] <= sat_add(start, ival_reg);
            end
            if (func_reg == FUNC_ADD)
                tgt_reg <= free_idx;
        end
        if (cmd.rearm && repeats_reg[min_idx_reg])
            deadline_reg[min_idx_reg] <= sat_add(now_reg, period_reg[min_idx_reg]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            exp_reg    <= '0;
            front_reg  <= 1'b0;
            found_reg  <= 1'b0;
            roll_reg   <= 1'b0;
            prev_reg   <= '0;
        end
        else
        begin
            if (cmd.scan_start)
                found_reg <= 1'b0;
            else if (cmd.scan_step && better)
                found_reg <= 1'b1;
            if (cmd.do_op)
            begin
                if (func_reg == FUNC_ADD)
                    active_reg[op_slot] <= 1'b1;
                else if (func_reg == FUNC_CANCEL)
                    active_reg[op_slot] <= 1'b0;
            end
            if (cmd.upd_prev)
            begin
                roll_reg <= stat.roll;
                prev_reg <= now_reg;
            end
            if (cmd.mark_exp)
            begin
                for (int i = 0; i < MAX_TIMERS; i++)
                    exp_reg[i] <= active_reg[i] && (roll_reg || deadline_reg[i] <= now_reg);
            end
            if (cmd.exp_clear)
                exp_reg[min_idx_reg] <= 1'b0;
            if (cmd.rearm && !repeats_reg[min_idx_reg])
                active_reg[min_idx_reg] <= 1'b0;
            if (cmd.clr_front)
                front_reg <= 1'b0;
            else if (cmd.front_check && stat.min_is_tgt)
                front_reg <= 1'b1;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mark_exp |=> (exp_reg & ~active_reg) == '0)
        else $error("expired mask holds an inactive slot");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step && cmd.scan_start |-> 1'b0)
        else $error("scan step and start together");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_front |=> !front_reg)
        else $error("front pending not cleared");
endmodule
`default_nettype wire

### hdl/dots_ctrl.sv
// Controller of the timer set: sequences scans, updates and result items.
// Depends on dots_pkg.
`default_nettype none
module dots_ctrl
    import dots_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  func,
    output logic             load,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [ID_W-1:0]  result_id,
    output logic             want_delay,
    output logic             front_notify,
    output logic             last,
    output dots_cmd_t        cmd,
    input  wire dots_stat_t  stat
);
    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_OP, S_SCAN, S_AFTER, S_EXP_MARK, S_EXP_SCAN,
        S_EXP_EMIT, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic [2:0] func_reg, func_next;
    logic [ID_W-1:0] idx_reg, idx_next;
    logic [1:0] status_reg, status_next;
    logic [ID_W-1:0] rid_reg, rid_next;
    logic fn_reg, fn_next, last_reg, last_next, dly_reg, dly_next;
    logic [1:0] phase_reg, phase_next; // 0 insert check, 1 expire first, 2 next
    logic cont_reg, cont_next;         // last not yet decided for this expired item
    logic [ID_W:0] cnt_reg, cnt_next;

    assign in_ready     = state_reg == S_IDLE;
    assign load         = in_valid && in_ready;
    // The result is held back while last is still being decided.
    assign out_valid    = state_reg == S_OUT && !cont_reg;
    assign status       = status_reg;
    assign result_id    = rid_reg;
    assign front_notify = fn_reg;
    assign last         = last_reg;
    assign want_delay   = dly_reg;

    always_comb
    begin
        state_next = state_reg;
        func_next = func_reg;
        idx_next = idx_reg;
        status_next = status_reg;
        rid_next = rid_reg;
        fn_next = fn_reg;
        last_next = last_reg;
        dly_next = dly_reg;
        phase_next = phase_reg;
        cont_next = cont_reg;
        cnt_next = cnt_reg;
        cmd = '0;
        cmd.scan_idx = idx_reg;
        cmd.use_exp = state_reg == S_EXP_SCAN;
        unique case (state_reg)
            S_IDLE:
            begin
                if (load)
                begin
                    func_next = func;
                    state_next = S_DECIDE;
                    status_next = ST_OK;
                    rid_next = '0;
                    fn_next = 1'b0;
                    last_next = 1'b1;
                    dly_next = 1'b0;
                    cnt_next = '0;
                end
            end
            S_DECIDE:
            begin
                state_next = S_OUT;
                case (func_reg)
                    FUNC_ADD:
                        if (!stat.free_found) status_next = ST_FULL;
                        else
                        begin
                            rid_next = stat.free_idx;
                            state_next = S_OP;
                        end
                    FUNC_CANCEL, FUNC_REFRESH:
                        if (!stat.tgt_active) status_next = ST_INACTIVE;
                        else state_next = S_OP;
                    FUNC_RESET:
                        if (stat.reset_same) status_next = ST_OK;
                        else if (!stat.tgt_active) status_next = ST_INACTIVE;
                        else state_next = S_OP;
                    FUNC_EXPIRE, FUNC_NEXT:
                    begin
                        state_next = S_SCAN;
                        phase_next = (func_reg == FUNC_EXPIRE) ? 2'd1 : 2'd2;
                        if (func_reg == FUNC_NEXT)
                        begin
                            cmd.clr_front = 1'b1;
                            dly_next = 1'b1;
                        end
                        cmd.scan_start = 1'b1;
                        idx_next = '0;
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_OP:
            begin
                cmd.do_op = 1'b1;
                if (func_reg == FUNC_ADD || func_reg == FUNC_RESET)
                begin
                    state_next = S_SCAN;
                    phase_next = 2'd0;
                    cmd.scan_start = 1'b1;
                    idx_next = '0;
                end
                else
                    state_next = S_OUT;
            end
            S_SCAN, S_EXP_SCAN:
            begin
                cmd.scan_step = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == ID_W'(MAX_TIMERS - 1))
                    state_next = (state_reg == S_SCAN) ? S_AFTER : S_EXP_EMIT;
            end
            S_AFTER:
            begin
                state_next = S_OUT;
                if (phase_reg == 2'd0)
                begin
                    cmd.front_check = 1'b1;
                    fn_next = stat.min_is_tgt && !stat.front_pending;
                end
                else if (phase_reg == 2'd1)
                begin
                    if (!stat.min_found)
                        status_next = ST_NONE;
                    else
                    begin
                        cmd.upd_prev = 1'b1;
                        if (!stat.roll && !stat.min_passed)
                            status_next = ST_NONE;
                        else
                            state_next = S_EXP_MARK;
                    end
                end
            end
            S_EXP_MARK:
            begin
                cmd.mark_exp = 1'b1;
                cmd.scan_start = 1'b1;
                idx_next = '0;
                state_next = S_EXP_SCAN;
            end
            S_EXP_EMIT:
            begin
                cmd.exp_clear = 1'b1;
                cmd.rearm = 1'b1;
                rid_next = stat.min_idx;
                cnt_next = cnt_reg + 1'b1;
                cont_next = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (cont_reg)
                begin
                    // Decide last once the remaining mask is known.
                    last_next = !stat.any_exp || cnt_reg == (ID_W+1)'(MAX_TIMERS);
                    cont_next = 1'b0;
                end
                else if (out_ready)
                begin
                    if (!last_reg)
                    begin
                        cmd.scan_start = 1'b1;
                        idx_next = '0;
                        state_next = S_EXP_SCAN;
                    end
                    else
                        state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            func_reg <= '0;
            idx_reg <= '0;
            status_reg <= '0;
            rid_reg <= '0;
            fn_reg <= 1'b0;
            last_reg <= 1'b0;
            dly_reg <= 1'b0;
            phase_reg <= '0;
            cont_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            func_reg <= func_next;
            idx_reg <= idx_next;
            status_reg <= status_next;
            rid_reg <= rid_next;
            fn_reg <= fn_next;
            last_reg <= last_next;
            dly_reg <= dly_next;
            phase_reg <= phase_next;
            cont_reg <= cont_next;
            cnt_reg <= cnt_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready && !cont_reg |=> out_valid && $stable(result_id))
        else $error("result item dropped while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("input taken while a result is pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (ID_W+1)'(MAX_TIMERS))
        else $error("too many expired items");
endmodule
`default_nettype wire

### bench/tb_deadline_ordered_timer_set_unit.sv
// Self-checking testbench for the deadline ordered timer set unit.
// Needs dots_pkg and deadline_ordered_timer_set_unit; items are predicted as they are queued.
`timescale 1ns / 100ps
module tb_deadline_ordered_timer_set_unit;
    import dots_pkg::*;

    typedef struct {
        logic [2:0]        func;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] ival;
        logic              rec;
        logic              fnow;
        logic [TIME_W-1:0] now;
    } timer_op_t;

    typedef struct {
        logic [1:0]        st;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] dly;
        logic              fn;
        logic              fin;
    } timer_res_t;

    localparam logic [2:0] FUNC_BAD6 = 3'd6;
    localparam logic [2:0] FUNC_BAD7 = 3'd7;

    logic clk;
    logic rst_n;
    logic in_valid, in_ready, out_valid, out_ready;
    logic [2:0] func;
    logic [ID_W-1:0] timer_id, result_id;
    logic [TIME_W-1:0] interval_ms, now_ms, delay_ms;
    logic recurring, restart_now, front_notify, last;
    logic [1:0] status;

    deadline_ordered_timer_set_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .timer_id(timer_id), .interval_ms(interval_ms),
        .recurring(recurring), .restart_now(restart_now), .now_ms(now_ms),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .result_id(result_id), .delay_ms(delay_ms),
        .front_notify(front_notify), .last(last)
    );

    timer_op_t  pending_ops[$];
    timer_res_t expected_res[$];
    int         errors = 0;
    int         accepted = 0;
    bit         stim_ready = 0;

    // Shadow copy of the timer table.
    logic [MAX_TIMERS-1:0] sh_active;
    logic [MAX_TIMERS-1:0] sh_written;
    logic [TIME_W-1:0]     sh_deadline[MAX_TIMERS];
    logic [TIME_W-1:0]     sh_period[MAX_TIMERS];
    logic                  sh_repeats[MAX_TIMERS];
    logic                  sh_front;
    logic [TIME_W-1:0]     sh_prev;
    logic [TIME_W-1:0]     cur_now;

    function automatic logic [TIME_W-1:0] add_sat(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? ALL_ONES : s[TIME_W-1:0];
    endfunction

    // Earliest slot by deadline, lower index winning ties; -1 if mask is empty.
    function automatic int first_due(logic [MAX_TIMERS-1:0] mask);
        int best;
        best = -1;
        for (int i = 0; i < MAX_TIMERS; i++)
            if (mask[i] && (best < 0 || sh_deadline[i] < sh_deadline[best]))
                best = i;
        return best;
    endfunction

    function automatic logic front_claim(int slot);
        if (first_due(sh_active) == slot && !sh_front) begin
            sh_front = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic post(logic [1:0] st, int id, logic [TIME_W-1:0] dly, logic fn, logic fin);
        timer_res_t r;
        r.st = st; r.id = id[ID_W-1:0]; r.dly = dly; r.fn = fn; r.fin = fin;
        expected_res.insert(expected_res.size(), r);
    endtask

    task automatic predict_timer_op(timer_op_t op);
        int slot, n;
        int order[$];
        logic [MAX_TIMERS-1:0] due;
        logic roll;
        logic [TIME_W-1:0] start;
        slot = -1;
        case (op.func)
            FUNC_ADD: begin
                for (int i = MAX_TIMERS - 1; i >= 0; i--)
                    if (!sh_active[i]) slot = i;
                if (slot < 0) post(ST_FULL, 0, 0, 0, 1);
                else begin
                    sh_active[slot] = 1'b1;
                    sh_written[slot] = 1'b1;
                    sh_period[slot] = op.ival;
                    sh_repeats[slot] = op.rec;
                    sh_deadline[slot] = add_sat(op.now, op.ival);
                    post(ST_OK, slot, 0, front_claim(slot), 1);
                end
            end
            FUNC_CANCEL: begin
                if (!sh_active[op.id]) post(ST_INACTIVE, 0, 0, 0, 1);
                else begin
                    sh_active[op.id] = 1'b0;
                    post(ST_OK, 0, 0, 0, 1);
                end
            end
            FUNC_REFRESH: begin
                if (!sh_active[op.id]) post(ST_INACTIVE, 0, 0, 0, 1);
                else begin
                    sh_deadline[op.id] = add_sat(op.now, sh_period[op.id]);
                    post(ST_OK, 0, 0, 0, 1);
                end
            end
            FUNC_RESET: begin
                if (op.ival == sh_period[op.id] && !op.fnow) post(ST_OK, 0, 0, 0, 1);
                else if (!sh_active[op.id]) post(ST_INACTIVE, 0, 0, 0, 1);
                else begin
                    if (op.fnow) start = op.now;
                    else if (sh_deadline[op.id] >= sh_period[op.id])
                        start = sh_deadline[op.id] - sh_period[op.id];
                    else start = 0;
                    sh_period[op.id] = op.ival;
                    sh_deadline[op.id] = add_sat(start, op.ival);
                    post(ST_OK, 0, 0, front_claim(op.id), 1);
                end
            end
            FUNC_EXPIRE: begin
                slot = first_due(sh_active);
                if (slot < 0) post(ST_NONE, 0, 0, 0, 1);
                else begin
                    roll = sh_prev >= HOUR_MS && op.now < sh_prev - HOUR_MS;
                    sh_prev = op.now;
                    if (!roll && sh_deadline[slot] > op.now) post(ST_NONE, 0, 0, 0, 1);
                    else begin
                        for (int i = 0; i < MAX_TIMERS; i++)
                            due[i] = sh_active[i] && (roll || sh_deadline[i] <= op.now);
                        while (first_due(due) >= 0) begin
                            slot = first_due(due);
                            due[slot] = 1'b0;
                            order.insert(order.size(), slot);
                        end
                        n = order.size();
                        for (int k = 0; k < n; k++) begin
                            if (sh_repeats[order[k]])
                                sh_deadline[order[k]] = add_sat(op.now, sh_period[order[k]]);
                            else sh_active[order[k]] = 1'b0;
                            post(ST_OK, order[k], 0, 0, k == n - 1);
                        end
                    end
                end
            end
            FUNC_NEXT: begin
                sh_front = 1'b0;
                slot = first_due(sh_active);
                if (slot < 0) post(ST_OK, 0, ALL_ONES, 0, 1);
                else if (op.now >= sh_deadline[slot]) post(ST_OK, 0, 0, 0, 1);
                else post(ST_OK, 0, sh_deadline[slot] - op.now, 0, 1);
            end
            default: ;
        endcase
    endtask

    task automatic queue_op(logic [2:0] f, int id, logic [TIME_W-1:0] ival, logic rec,
                            logic fnow, logic [TIME_W-1:0] now);
        timer_op_t op;
        op.func = f; op.id = id[ID_W-1:0]; op.ival = ival; op.rec = rec;
        op.fnow = fnow; op.now = now;
        // A reset that compares against a period never written must not occur.
        if (f == FUNC_RESET && !fnow && !sh_written[op.id] && ival == 0)
            op.ival = 1;
        predict_timer_op(op);
        pending_ops.insert(pending_ops.size(), op);
    endtask

    function automatic logic [TIME_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Stimulus and prediction.
    initial
    begin
        int pick, real_items;
        logic [TIME_W-1:0] ival;
        sh_active = '0; sh_written = '0; sh_front = 1'b0; sh_prev = '0;
        for (int i = 0; i < MAX_TIMERS; i++)
        begin
            sh_deadline[i] = '0; sh_period[i] = '0; sh_repeats[i] = 1'b0;
        end
        // Directed part: empty set, front notice, saturation, full table, rollover.
        queue_op(FUNC_NEXT, 0, 0, 0, 0, 0);
        queue_op(FUNC_EXPIRE, 0, 0, 0, 0, 0);
        queue_op(FUNC_CANCEL, 15, 0, 0, 0, 0);
        queue_op(FUNC_ADD, 0, 100, 1, 0, 0);
        queue_op(FUNC_ADD, 0, ALL_ONES, 0, 0, 5);
        queue_op(FUNC_ADD, 0, 0, 0, 0, 10);
        queue_op(FUNC_NEXT, 0, 0, 0, 0, 10);
        queue_op(FUNC_RESET, 0, 50, 0, 1, 20);
        queue_op(FUNC_RESET, 0, 50, 0, 0, 20);
        queue_op(FUNC_RESET, 1, 30, 0, 0, 25);
        queue_op(FUNC_REFRESH, 0, 0, 0, 0, 30);
        queue_op(FUNC_REFRESH, 9, 0, 0, 0, 30);
        queue_op(FUNC_BAD6, 3, 7, 1, 1, 30);
        queue_op(FUNC_EXPIRE, 0, 0, 0, 0, 40);
        for (int i = 0; i < 15; i++)
            queue_op(FUNC_ADD, 0, 64'(i * 3), i[0], 0, 40);
        queue_op(FUNC_NEXT, 0, 0, 0, 0, 41);
        queue_op(FUNC_EXPIRE, 0, 0, 0, 0, 64'd5000000);
        queue_op(FUNC_EXPIRE, 0, 0, 0, 0, 64'd100);
        queue_op(FUNC_BAD7, 0, 0, 0, 0, 100);
        cur_now = 64'd36000000;
        real_items = 0;
        while (real_items < 330)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 3 && cur_now > 2 * HOUR_MS) cur_now = cur_now - HOUR_MS - $urandom_range(1, 9999);
            else if (pick < 5) cur_now = rand64();
            else if (pick < 7) cur_now = 64'd36000000;
            else cur_now = add_sat(cur_now, $urandom_range(0, 300));
            ival = ($urandom_range(0, 19) == 0) ? rand64() : 64'($urandom_range(0, 1500));
            pick = $urandom_range(0, 104);
            if (pick >= 100)
                queue_op($urandom_range(0, 1) ? FUNC_BAD6 : FUNC_BAD7, $urandom_range(0, 15),
                         rand64(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), cur_now);
            else
            begin
                real_items++;
                if (pick < 25)
                    queue_op(FUNC_ADD, $urandom_range(0, 15), ival, 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), cur_now);
                else if (pick < 35)
                    queue_op(FUNC_CANCEL, $urandom_range(0, 15), ival, 0, 0, cur_now);
                else if (pick < 45)
                    queue_op(FUNC_REFRESH, $urandom_range(0, 15), ival, 0, 0, cur_now);
                else if (pick < 60)
                    queue_op(FUNC_RESET, $urandom_range(0, 15), ival, 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), cur_now);
                else if (pick < 82)
                    queue_op(FUNC_EXPIRE, $urandom_range(0, 15), ival, 0, 0, cur_now);
                else
                    queue_op(FUNC_NEXT, $urandom_range(0, 15), ival, 0, 0, cur_now);
            end
        end
        stim_ready = 1;
        wait (pending_ops.size() == 0 && !in_valid && expected_res.size() == 0);
        repeat (400) @(posedge clk);
        if (errors == 0)
            $display("[deadline_ordered_timer_set_unit] OK");
        else
            $display("[deadline_ordered_timer_set_unit] ERROR");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("[deadline_ordered_timer_set_unit] ERROR");
        $finish;
    end

    // Items 150 to 229 go through with neither side idling.
    wire calm = accepted >= 150 && accepted < 230;

    always @(posedge clk or negedge rst_n)
    begin
        timer_op_t op;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            func <= '0; timer_id <= '0; interval_ms <= '0;
            recurring <= 1'b0; restart_now <= 1'b0; now_ms <= '0;
        end
        else
        begin
            if (in_valid && in_ready) accepted <= accepted + 1;
            if (!in_valid || in_ready)
            begin
                if (stim_ready && pending_ops.size() > 0 && (calm || $urandom_range(0, 99) >= 34))
                begin
                    op = pending_ops.pop_front();
                    in_valid <= 1'b1;
                    func <= op.func; timer_id <= op.id; interval_ms <= op.ival;
                    recurring <= op.rec; restart_now <= op.fnow; now_ms <= op.now;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        timer_res_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            out_ready <= calm || $urandom_range(0, 99) >= 34;
            if (out_valid && out_ready)
            begin
                if (expected_res.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual st=%0d id=%0d", $time,
                             status, result_id);
                end
                else
                begin
                    want = expected_res.pop_front();
                    if (status !== want.st || result_id !== want.id || delay_ms !== want.dly ||
                        front_notify !== want.fn || last !== want.fin)
                    begin
                        errors++;
                        $display("%0t: mismatch expected st=%0d id=%0d dly=%h fn=%0b last=%0b",
                                 $time, want.st, want.id, want.dly, want.fn, want.fin);
                        $display("%0t:          actual   st=%0d id=%0d dly=%h fn=%0b last=%0b",
                                 $time, status, result_id, delay_ms, front_notify, last);
                    end
                end
            end
        end
    end
endmodule
